// ===== sv/aocw_pkg.sv =====
// Shared types and constants for the ADC offset calibrator with over-current watch.
package aocw_pkg;

  localparam logic [2:0] ST_RESTARTED = 3'd0;
  localparam logic [2:0] ST_STORED    = 3'd1;
  localparam logic [2:0] ST_NOISY     = 3'd2;
  localparam logic [2:0] ST_CAL_DONE  = 3'd3;
  localparam logic [2:0] ST_RANGE_ERR = 3'd4;
  localparam logic [2:0] ST_IGNORED   = 3'd5;
  localparam logic [2:0] ST_OK        = 3'd6;
  localparam logic [2:0] ST_TRIP      = 3'd7;

  localparam logic [1:0] MODE_SAMPLING   = 2'd0;
  localparam logic [1:0] MODE_CALIBRATED = 2'd1;
  localparam logic [1:0] MODE_RANGE_ERR  = 2'd2;

  localparam logic [11:0] ADC_MAX = 12'hFFF;

  localparam logic [1:0] REG_NOISE_THRESHOLD    = 2'd0;
  localparam logic [1:0] REG_HYSTERESIS         = 2'd1;
  localparam logic [1:0] REG_MAX_CURRENT_COUNTS = 2'd2;
  localparam logic [1:0] REG_TRIP_HITS          = 2'd3;

  localparam logic [7:0]  RST_NOISE_THRESHOLD    = 8'd8;
  localparam logic [11:0] RST_HYSTERESIS         = 12'd16;
  localparam logic [11:0] RST_MAX_CURRENT_COUNTS = 12'd2048;
  localparam logic [3:0]  RST_TRIP_HITS          = 4'd3;

  typedef struct packed {
    logic        cmd;
    logic [11:0] sample;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [11:0] offset;
    logic [11:0] high_threshold;
    logic [3:0]  hit_count;
    logic        calibrated;
  } out_t;

  typedef struct packed {
    logic [7:0]  noise_threshold;
    logic [11:0] hysteresis;
    logic [11:0] max_current_counts;
    logic [3:0]  trip_hits;
  } cfg_t;

  typedef struct packed {
    logic accept;
    logic div_step;
    logic sq_init;
    logic sq_rd;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic last;
    logic sq_busy;
  } dp_sts_t;

endpackage

// ===== sv/aocw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module aocw_ram #(
  parameter int W = 12,
  parameter int D = 64
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/aocw_ctrl.sv =====
// Sequencer for item acceptance, offset division and the deviation pass.
module aocw_ctrl #(
  parameter int SAMPLES = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  aocw_pkg::dp_sts_t          sts,
  output aocw_pkg::dp_cmd_t          ctl,
  output logic [$clog2(SAMPLES)-1:0] idx
);

  localparam int AW = $clog2(SAMPLES);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_SQ   = 3'd2;
  localparam logic [2:0] S_SQW  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]    state, state_next;
  logic [AW-1:0] cnt, cnt_next;
  logic          accept;

  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);
  assign accept   = in_valid && !in_stall;
  assign idx      = cnt;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    ctl        = '0;
    unique case (state)
      S_IDLE: begin
        ctl.accept = accept;
        if (accept && sts.last) begin
          state_next = S_DIV;
          cnt_next   = '0;
        end
      end
      S_DIV: begin
        ctl.div_step = 1'b1;
        ctl.sq_init  = 1'b1;
        state_next   = S_SQ;
      end
      S_SQ: begin
        ctl.sq_rd = 1'b1;
        if (cnt == AW'(SAMPLES - 1)) begin
          cnt_next   = '0;
          state_next = S_SQW;
        end else begin
          cnt_next = cnt + AW'(1);
        end
      end
      S_SQW: begin
        if (!sts.sq_busy) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        ctl.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  a_fin_then_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) |=> (state == S_IDLE))
    else $error("finish step not followed by idle");

  a_div_to_sq: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && cnt == '0) |=> (state == S_SQ && cnt == '0))
    else $error("division did not hand over to the deviation pass");

  a_only_idle_accepts: assert property (@(posedge clk) disable iff (rst)
    ctl.accept |-> (state == S_IDLE && !(out_valid && out_stall)))
    else $error("item accepted while busy or while the result waits");

endmodule

// ===== sv/aocw_dp.sv =====
// Datapath: sample store, offset computation, deviation accumulator and watch logic.
module aocw_dp #(
  parameter int SAMPLES = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  aocw_pkg::cfg_t             cfg,
  input  aocw_pkg::in_t              in_data,
  input  aocw_pkg::dp_cmd_t          ctl,
  input  logic [$clog2(SAMPLES)-1:0] idx,
  output aocw_pkg::dp_sts_t          sts,
  output logic                       out_valid,
  input  logic                       out_stall,
  output aocw_pkg::out_t             out_data
);

  localparam int AW   = $clog2(SAMPLES);
  localparam int TW   = AW + 12;
  localparam int SQW  = AW + 24;
  localparam int LIMW = AW + 17;
  localparam int KSH  = TW + AW;
  localparam int RW   = TW + 1;
  localparam int PW   = 2 * TW + 1;
  localparam logic [RW-1:0] RECIP =
    RW'(((64'd1 << KSH) + 64'(SAMPLES) - 64'd1) / 64'(SAMPLES));
  localparam logic [LIMW-1:0] DM1  = LIMW'(SAMPLES - 1);

  logic [1:0]    mode, mode_next;
  logic [3:0]    hits, hits_next;
  logic [AW-1:0] count, count_next;
  logic [11:0]   offset_reg, offset_next;
  logic [11:0]   threshold_reg, threshold_next;
  logic [TW-1:0] total, total_next;
  logic [11:0]   quot, quot_next;

  logic [SQW-1:0]  sq;
  logic [23:0]     prod;
  logic            rd_v, prod_v;
  logic [15:0]     nsq;
  logic [LIMW-1:0] lim;

  logic [11:0] rdata;
  logic [11:0] adev;
  logic        we;
  logic [PW-1:0] qprod;
  logic [3:0]  hit_inc;
  logic        over, under;
  logic        noisy;
  logic [13:0] high;
  logic [2:0]  status;
  logic        load;

  aocw_ram #(.W(12), .D(SAMPLES)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (count),
    .wdata (in_data.sample),
    .raddr (idx),
    .rdata (rdata)
  );

  assign we = ctl.accept && !in_data.cmd && (mode == aocw_pkg::MODE_SAMPLING);

  assign sts.last = !in_data.cmd && (mode == aocw_pkg::MODE_SAMPLING)
                    && (count == AW'(SAMPLES - 1));
  assign sts.sq_busy = rd_v || prod_v;

  assign qprod   = PW'(total) * PW'(RECIP);
  assign adev    = (rdata >= quot) ? (rdata - quot) : (quot - rdata);
  assign hit_inc = hits + 4'd1;
  assign over    = in_data.sample > threshold_reg;
  assign under   = ({1'b0, in_data.sample} + {1'b0, cfg.hysteresis}) < {1'b0, threshold_reg};
  assign noisy   = sq >= SQW'(lim);
  assign high    = 14'(cfg.max_current_counts) + 14'(quot)
                   + 14'({cfg.noise_threshold, 2'b00});

  always_comb begin
    mode_next      = mode;
    hits_next      = hits;
    count_next     = count;
    offset_next    = offset_reg;
    threshold_next = threshold_reg;
    total_next     = total;
    quot_next      = quot;
    status         = aocw_pkg::ST_OK;
    load           = 1'b0;
    if (ctl.accept) begin
      if (in_data.cmd) begin
        count_next = '0;
        hits_next  = '0;
        total_next = '0;
        mode_next  = aocw_pkg::MODE_SAMPLING;
        status     = aocw_pkg::ST_RESTARTED;
        load       = 1'b1;
      end else if (mode == aocw_pkg::MODE_SAMPLING) begin
        total_next = total + TW'(in_data.sample);
        if (sts.last) begin
          count_next = '0;
        end else begin
          count_next = count + AW'(1);
          status     = aocw_pkg::ST_STORED;
          load       = 1'b1;
        end
      end else if (mode == aocw_pkg::MODE_CALIBRATED) begin
        load = 1'b1;
        if (over) begin
          if (hit_inc >= cfg.trip_hits) begin
            hits_next = '0;
            status    = aocw_pkg::ST_TRIP;
          end else begin
            hits_next = hit_inc;
          end
        end else if (under) begin
          hits_next = '0;
        end
      end else begin
        status = aocw_pkg::ST_IGNORED;
        load   = 1'b1;
      end
    end else if (ctl.div_step) begin
      quot_next = qprod[KSH +: 12];
    end else if (ctl.finish) begin
      load        = 1'b1;
      count_next  = '0;
      total_next  = '0;
      offset_next = quot;
      if (noisy) begin
        status = aocw_pkg::ST_NOISY;
      end else if (high > 14'(aocw_pkg::ADC_MAX)) begin
        mode_next = aocw_pkg::MODE_RANGE_ERR;
        status    = aocw_pkg::ST_RANGE_ERR;
      end else begin
        threshold_next = high[11:0];
        mode_next      = aocw_pkg::MODE_CALIBRATED;
        hits_next      = '0;
        status         = aocw_pkg::ST_CAL_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= aocw_pkg::MODE_SAMPLING;
      hits          <= '0;
      count         <= '0;
      offset_reg    <= '0;
      threshold_reg <= aocw_pkg::ADC_MAX;
      total         <= '0;
      rd_v          <= 1'b0;
      prod_v        <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      mode          <= mode_next;
      hits          <= hits_next;
      count         <= count_next;
      offset_reg    <= offset_next;
      threshold_reg <= threshold_next;
      total         <= total_next;
      rd_v          <= ctl.sq_rd;
      prod_v        <= rd_v;
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    quot <= quot_next;
    prod <= 24'(adev) * 24'(adev);
    nsq  <= 16'(cfg.noise_threshold) * 16'(cfg.noise_threshold);
    lim  <= (LIMW'(nsq) + LIMW'(1)) * DM1;
    if (ctl.sq_init) begin
      sq <= '0;
    end else if (prod_v) begin
      sq <= sq + SQW'(prod);
    end
    if (load) begin
      out_data.status         <= status;
      out_data.offset         <= offset_next;
      out_data.high_threshold <= threshold_next;
      out_data.hit_count      <= hits_next;
      out_data.calibrated     <= (mode_next == aocw_pkg::MODE_CALIBRATED);
    end
  end

  a_cal_thr_above_offset: assert property (@(posedge clk) disable iff (rst)
    (mode == aocw_pkg::MODE_CALIBRATED) |-> (threshold_reg >= offset_reg))
    else $error("calibrated threshold below offset");

  a_finish_after_drain: assert property (@(posedge clk) disable iff (rst)
    ctl.finish |-> !(rd_v || prod_v))
    else $error("finish step while deviation pipeline still busy");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> !(out_valid && out_stall))
    else $error("result register loaded while a beat still waits");

endmodule

// ===== sv/adc_offset_calibrator_overcurrent_watch.sv =====
// Top level: configuration registers, sequencer and datapath of the offset calibrator.
//
// The block collects SAMPLES current samples into a RAM, takes the floor of their
// mean as the offset, checks the spread of the set against noise_threshold and, if
// the set is quiet and the threshold in range, sets the over-current threshold,
// after which it counts samples above that threshold and reports a trip after
// trip_hits hits. Every beat gives one result. The sample that completes a set
// is followed, in order, by a step that forms the offset by multiplying the sum
// with a constant reciprocal, one pass over the sample RAM through its single
// read port, a drain of the squaring pipeline and a final step. The sample RAM
// needs no clearing after reset.
module adc_offset_calibrator_overcurrent_watch #(
  parameter int SAMPLES = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  aocw_pkg::in_t        in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output aocw_pkg::out_t       out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [3:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int AW = $clog2(SAMPLES);

  aocw_pkg::cfg_t    cfg;
  aocw_pkg::dp_cmd_t ctl;
  aocw_pkg::dp_sts_t sts;
  logic [AW-1:0]     idx;
  logic              wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.noise_threshold    <= aocw_pkg::RST_NOISE_THRESHOLD;
      cfg.hysteresis         <= aocw_pkg::RST_HYSTERESIS;
      cfg.max_current_counts <= aocw_pkg::RST_MAX_CURRENT_COUNTS;
      cfg.trip_hits          <= aocw_pkg::RST_TRIP_HITS;
    end else if (wr) begin
      unique case (paddr[3:2])
        aocw_pkg::REG_NOISE_THRESHOLD:    cfg.noise_threshold    <= pwdata[7:0];
        aocw_pkg::REG_HYSTERESIS:         cfg.hysteresis         <= pwdata[11:0];
        aocw_pkg::REG_MAX_CURRENT_COUNTS: cfg.max_current_counts <= pwdata[11:0];
        aocw_pkg::REG_TRIP_HITS:          cfg.trip_hits          <= pwdata[3:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      aocw_pkg::REG_NOISE_THRESHOLD:    prdata = 32'(cfg.noise_threshold);
      aocw_pkg::REG_HYSTERESIS:         prdata = 32'(cfg.hysteresis);
      aocw_pkg::REG_MAX_CURRENT_COUNTS: prdata = 32'(cfg.max_current_counts);
      aocw_pkg::REG_TRIP_HITS:          prdata = 32'(cfg.trip_hits);
      default:                          prdata = '0;
    endcase
  end

  aocw_ctrl #(.SAMPLES(SAMPLES)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .ctl       (ctl),
    .idx       (idx)
  );

  aocw_dp #(.SAMPLES(SAMPLES)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_data   (in_data),
    .ctl       (ctl),
    .idx       (idx),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== dv/tb_adc_offset_calibrator_overcurrent_watch.sv =====
// Testbench for the ADC offset calibrator with over-current watch, self-checking via scoreboard.
module tb_adc_offset_calibrator_overcurrent_watch;

  localparam int NSAMP = 64;

  class calib_scoreboard;
    logic [7:0]  noise_thr;
    logic [11:0] hyst;
    logic [11:0] max_cur;
    logic [3:0]  trip_n;
    logic [11:0] store [NSAMP];
    int          fill;
    logic [11:0] offs;
    logic [11:0] thr;
    logic [1:0]  mode;
    logic [3:0]  hits;
    aocw_pkg::out_t expected_results [$];
    int          errors;
    int          n_checked;
    int          status_seen [8];

    function new();
      noise_thr = aocw_pkg::RST_NOISE_THRESHOLD;
      hyst = aocw_pkg::RST_HYSTERESIS;
      max_cur = aocw_pkg::RST_MAX_CURRENT_COUNTS;
      trip_n = aocw_pkg::RST_TRIP_HITS;
      fill = 0;
      offs = '0;
      thr = aocw_pkg::ADC_MAX;
      mode = aocw_pkg::MODE_SAMPLING;
      hits = '0;
      errors = 0;
      n_checked = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function logic [31:0] set_reg(logic [1:0] idx, logic [31:0] v);
      case (idx)
        aocw_pkg::REG_NOISE_THRESHOLD: begin
          noise_thr = v[7:0];
          return {24'd0, v[7:0]};
        end
        aocw_pkg::REG_HYSTERESIS: begin
          hyst = v[11:0];
          return {20'd0, v[11:0]};
        end
        aocw_pkg::REG_MAX_CURRENT_COUNTS: begin
          max_cur = v[11:0];
          return {20'd0, v[11:0]};
        end
        default: begin
          trip_n = v[3:0];
          return {28'd0, v[3:0]};
        end
      endcase
    endfunction

    function logic [2:0] close_set();
      int unsigned       total;
      longint            dev;
      longint unsigned   sq;
      int                high;
      total = 0;
      sq = 0;
      foreach (store[i]) total += store[i];
      offs = 12'(total / NSAMP);
      foreach (store[i]) begin
        dev = longint'(store[i]) - longint'(offs);
        sq += longint'(dev * dev);
      end
      fill = 0;
      if (sq / (NSAMP - 1) > longint'(noise_thr) * longint'(noise_thr))
        return aocw_pkg::ST_NOISY;
      high = int'(max_cur) + int'(offs) + 4 * int'(noise_thr);
      if (high > int'(aocw_pkg::ADC_MAX)) begin
        mode = aocw_pkg::MODE_RANGE_ERR;
        return aocw_pkg::ST_RANGE_ERR;
      end
      thr = 12'(high);
      mode = aocw_pkg::MODE_CALIBRATED;
      hits = '0;
      return aocw_pkg::ST_CAL_DONE;
    endfunction

    function logic [2:0] watch(logic [11:0] s);
      if (s > thr) begin
        hits = hits + 4'd1;
        if (hits >= trip_n) begin
          hits = '0;
          return aocw_pkg::ST_TRIP;
        end
      end else if (int'(s) + int'(hyst) < int'(thr)) begin
        hits = '0;
      end
      return aocw_pkg::ST_OK;
    endfunction

    function void predict_beat(aocw_pkg::in_t x);
      aocw_pkg::out_t want;
      logic [2:0] st;
      if (x.cmd) begin
        fill = 0;
        hits = '0;
        mode = aocw_pkg::MODE_SAMPLING;
        st = aocw_pkg::ST_RESTARTED;
      end else if (mode == aocw_pkg::MODE_SAMPLING) begin
        if (fill >= NSAMP) fill = 0;
        store[fill] = x.sample;
        fill++;
        st = (fill >= NSAMP) ? close_set() : aocw_pkg::ST_STORED;
      end else if (mode == aocw_pkg::MODE_CALIBRATED) begin
        st = watch(x.sample);
      end else begin
        st = aocw_pkg::ST_IGNORED;
      end
      status_seen[st]++;
      want.status = st;
      want.offset = offs;
      want.high_threshold = thr;
      want.hit_count = hits;
      want.calibrated = (mode == aocw_pkg::MODE_CALIBRATED);
      expected_results.push_back(want);
    endfunction

    function void compare_field(string name, logic [11:0] want, logic [11:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(aocw_pkg::out_t got);
      aocw_pkg::out_t want;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, got %h", $time, got);
        return;
      end
      want = expected_results.pop_front();
      n_checked++;
      compare_field("status", 12'(want.status), 12'(got.status));
      compare_field("offset", want.offset, got.offset);
      compare_field("high_threshold", want.high_threshold, got.high_threshold);
      compare_field("hit_count", 12'(want.hit_count), 12'(got.hit_count));
      compare_field("calibrated", 12'(want.calibrated), 12'(got.calibrated));
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic           clk;
  logic           rst = 1'b1;
  logic           in_valid = 1'b0;
  logic           in_stall;
  aocw_pkg::in_t  in_data = '0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  aocw_pkg::out_t out_data;
  logic           psel = 1'b0;
  logic           penable = 1'b0;
  logic           pwrite = 1'b0;
  logic [3:0]     paddr = '0;
  logic [31:0]    pwdata = '0;
  logic [31:0]    prdata;
  logic           pready;

  calib_scoreboard sb = new();
  bit quiet = 1'b0;
  int items_sent = 0;
  int stall_left = 0;

  adc_offset_calibrator_overcurrent_watch #(.SAMPLES(NSAMP)) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #8000000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(12, 60);
  endfunction

  function automatic int clamp_adc(int v);
    if (v < 0) return 0;
    if (v > 4095) return 4095;
    return v;
  endfunction

  function automatic aocw_pkg::in_t make_beat(logic cmd, int s);
    aocw_pkg::in_t x;
    x.cmd = cmd;
    x.sample = s[11:0];
    return x;
  endfunction

  function automatic int rand_hyst();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 0;
    if (r < 25) return 4095;
    return $urandom_range(0, 64);
  endfunction

  function automatic int rand_trip();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 0;
    if (r < 20) return 15;
    return $urandom_range(1, 6);
  endfunction

  always @(negedge clk) begin
    if (rst || quiet) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 99) < 25) begin
      stall_left <= ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2) : $urandom_range(10, 50);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_stall === 1'b0) sb.predict_beat(in_data);
      if (out_valid === 1'b1 && !out_stall) sb.check_result(out_data);
    end
  end

  task automatic send_beat(input aocw_pkg::in_t x);
    int gap;
    gap = quiet ? 0 : pick_gap();
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= x;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    items_sent++;
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input int val);
    logic [31:0] got;
    logic [31:0] want;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    @(negedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    got = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    want = sb.set_reg(idx, val);
    if (got !== want) begin
      sb.errors++;
      $display("%0t: register %0d readback mismatch, expected %0d, got %0d",
               $time, idx, want, got);
    end
  endtask

  task automatic calib_set(input int base, input int spread);
    send_beat(make_beat(1'b1, $urandom_range(0, 4095)));
    repeat (NSAMP)
      send_beat(make_beat(1'b0, clamp_adc(base - spread + int'($urandom_range(0, 2 * spread)))));
  endtask

  task automatic run_watch(input int n);
    int t;
    int lo;
    int pick;
    repeat (n) begin
      t = sb.thr;
      lo = t - int'(sb.hyst);
      if (lo < 0) lo = 0;
      pick = $urandom_range(0, 99);
      if (pick < 2)
        send_beat(make_beat(1'b1, $urandom_range(0, 4095)));
      else if (pick < 42)
        send_beat(make_beat(1'b0, (t >= 4095) ? 4095 : $urandom_range(t + 1, 4095)));
      else if (pick < 67)
        send_beat(make_beat(1'b0, $urandom_range(lo, t)));
      else if (pick < 85)
        send_beat(make_beat(1'b0, $urandom_range(0, t)));
      else
        send_beat(make_beat(1'b0, $urandom_range(0, 4095)));
    end
  endtask

  initial begin
    int nt;
    int base;
    int mc;
    int pick;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Short directed run with reset configuration.
    send_beat(make_beat(1'b0, 4095));
    send_beat(make_beat(1'b0, 0));
    send_beat(make_beat(1'b1, 4095));
    send_beat(make_beat(1'b0, 12'hAAA));
    send_beat(make_beat(1'b0, 12'h555));
    send_beat(make_beat(1'b1, 0));
    settle();

    // Quiet set at the lower register extremes, then single-hit trips and the hysteresis edge.
    write_reg(aocw_pkg::REG_NOISE_THRESHOLD, 0);
    write_reg(aocw_pkg::REG_HYSTERESIS, 0);
    write_reg(aocw_pkg::REG_MAX_CURRENT_COUNTS, 0);
    write_reg(aocw_pkg::REG_TRIP_HITS, 0);
    calib_set(1000, 0);
    send_beat(make_beat(1'b0, 1001));
    send_beat(make_beat(1'b0, 1000));
    send_beat(make_beat(1'b0, 999));
    send_beat(make_beat(1'b0, 4095));
    send_beat(make_beat(1'b0, 0));
    settle();
    write_reg(aocw_pkg::REG_TRIP_HITS, 15);
    write_reg(aocw_pkg::REG_HYSTERESIS, 4095);
    run_watch(40);
    settle();

    // Noisy set with zero allowance, then a range error at the upper extremes.
    calib_set(1500, 3);
    run_watch(5);
    settle();
    write_reg(aocw_pkg::REG_NOISE_THRESHOLD, 255);
    write_reg(aocw_pkg::REG_MAX_CURRENT_COUNTS, 4095);
    calib_set(2000, 100);
    run_watch(6);
    settle();

    while (items_sent < 1150) begin
      quiet = ($urandom_range(0, 9) < 3);
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        nt = $urandom_range(1, 40);
        base = $urandom_range(50, 2500);
        mc = $urandom_range(0, 4095 - base - 5 * nt - 8);
        write_reg(aocw_pkg::REG_NOISE_THRESHOLD, nt);
        write_reg(aocw_pkg::REG_MAX_CURRENT_COUNTS, mc);
        write_reg(aocw_pkg::REG_HYSTERESIS, rand_hyst());
        write_reg(aocw_pkg::REG_TRIP_HITS, rand_trip());
        calib_set(base, $urandom_range(0, nt));
        run_watch($urandom_range(20, 100));
        settle();
        write_reg(aocw_pkg::REG_HYSTERESIS, rand_hyst());
        write_reg(aocw_pkg::REG_TRIP_HITS, rand_trip());
        run_watch($urandom_range(20, 100));
      end else if (pick < 72) begin
        nt = $urandom_range(0, 10);
        write_reg(aocw_pkg::REG_NOISE_THRESHOLD, nt);
        calib_set($urandom_range(100, 3900), 3 * nt + $urandom_range(5, 200));
        run_watch($urandom_range(2, 10));
      end else if (pick < 84) begin
        nt = $urandom_range(0, 255);
        write_reg(aocw_pkg::REG_NOISE_THRESHOLD, nt);
        write_reg(aocw_pkg::REG_MAX_CURRENT_COUNTS, 4095 - $urandom_range(0, 300));
        calib_set($urandom_range(100, 3000), $urandom_range(0, nt));
        run_watch($urandom_range(3, 10));
      end else begin
        repeat (30)
          send_beat(make_beat($urandom_range(0, 9) == 0, $urandom_range(0, 4095)));
      end
      settle();
    end

    quiet = 1'b0;
    settle();
    repeat (100) @(posedge clk);
    $display("Sent %0d input beats and checked %0d results.", items_sent, sb.n_checked);
    $display("Seen: %0d calibrations, %0d noisy sets, %0d range errors, %0d trips, %0d ignored.",
             sb.status_seen[aocw_pkg::ST_CAL_DONE], sb.status_seen[aocw_pkg::ST_NOISY],
             sb.status_seen[aocw_pkg::ST_RANGE_ERR], sb.status_seen[aocw_pkg::ST_TRIP],
             sb.status_seen[aocw_pkg::ST_IGNORED]);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
